@@ rtl/drbm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// drbm_pkg: shared types and constants of the dirty tile bitmap
// Field widths, mode and register codes, payload structs and the
// command/status bundle between controller and datapath.
// ----------------------------------------------------------------------------
package drbm_pkg;

    localparam int PIX_W     = 13;
    localparam int TNUM_W    = 14;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_MARK  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 2'd1;

    localparam logic [CFG_W-1:0] CFG_RESET_COUNT = 8'd128;

    typedef struct packed {
        logic [1:0]        mode;
        logic [PIX_W-1:0]  rect_left;
        logic [PIX_W-1:0]  rect_top;
        logic [PIX_W-1:0]  rect_width;
        logic [PIX_W-1:0]  rect_height;
        logic [PIX_W-1:0]  area_left;
        logic [PIX_W-1:0]  area_top;
        logic [TNUM_W-1:0] tile_number;
    } t_in;

    typedef struct packed {
        logic       tile_dirty;
        logic [1:0] done_mode;
    } t_out;

    typedef struct packed {
        logic       capture;
        logic       span;
        logic       mul;
        logic [1:0] mul_sel;
        logic       clip;
        logic       clr_setup;
        logic       row_rd;
        logic       row_wr;
        logic       div_start;
        logic       flag_rd;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic last_row;
        logic div_done;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/drbm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// drbm_ctrl: sequencer of the dirty tile bitmap
// Steps each transaction through span, scaling, clipping, row
// read-modify-write or the tile number division, and owns the output valid.
// ----------------------------------------------------------------------------
module drbm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_mode,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire drbm_pkg::t_status i_status,
    output drbm_pkg::t_cmd         o_cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SPAN     = 4'd1;
    localparam logic [3:0] ST_MUL      = 4'd2;
    localparam logic [3:0] ST_CLIP     = 4'd3;
    localparam logic [3:0] ST_CLR      = 4'd4;
    localparam logic [3:0] ST_ROW_RD   = 4'd5;
    localparam logic [3:0] ST_ROW_WR   = 4'd6;
    localparam logic [3:0] ST_DIV_GO   = 4'd7;
    localparam logic [3:0] ST_DIV_WAIT = 4'd8;
    localparam logic [3:0] ST_FLAG_RD  = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_in_mode)
                        drbm_pkg::MODE_CLEAR: n_state = ST_CLR;
                        drbm_pkg::MODE_MARK:  n_state = ST_SPAN;
                        drbm_pkg::MODE_READ:  n_state = ST_DIV_GO;
                        default:              n_state = ST_DONE;
                    endcase
                end
            end
            ST_SPAN: begin
                o_cmd.span = 1'b1;
                n_sel      = 2'd0;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul     = 1'b1;
                o_cmd.mul_sel = r_sel;
                n_sel         = r_sel + 2'd1;
                if (r_sel == 2'd3) begin
                    n_state = ST_CLIP;
                end
            end
            ST_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = ST_ROW_RD;
            end
            ST_CLR: begin
                o_cmd.clr_setup = 1'b1;
                n_state         = ST_ROW_RD;
            end
            ST_ROW_RD: begin
                // drop rectangles that are empty or fall outside the grid
                if (i_status.skip) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.row_rd = 1'b1;
                    n_state      = ST_ROW_WR;
                end
            end
            ST_ROW_WR: begin
                o_cmd.row_wr = 1'b1;
                n_state      = i_status.last_row ? ST_DONE : ST_ROW_RD;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_FLAG_RD;
                end
            end
            ST_FLAG_RD: begin
                o_cmd.flag_rd = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ rtl/drbm_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// drbm_divider: restoring divider, one quotient bit per cycle
// Splits a tile number into row and column by the number of tile columns.
// ----------------------------------------------------------------------------
module drbm_divider #(
    parameter int DVD_W = 14,
    parameter int DVS_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quotient,
    output logic [DVS_W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift dividend bits out at the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

@@ rtl/drbm_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// drbm_datapath: tile map storage and arithmetic
// Holds the registers, the row memory with per-row valid bits, the pixel to
// tile scaling, clipping, row masks and the tile number divider.
// ----------------------------------------------------------------------------
module drbm_datapath #(
    parameter int TILE_SIZE        = 16,
    parameter int MAX_TILES_ACROSS = 128,
    parameter int MAX_TILES_DOWN   = 128
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire drbm_pkg::t_in                     i_in_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [drbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [drbm_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire drbm_pkg::t_cmd                    i_cmd,
    output drbm_pkg::t_status                      o_status,
    output drbm_pkg::t_out                         o_out_data
);

    localparam int AW     = $clog2(MAX_TILES_ACROSS + 1);
    localparam int DNW    = $clog2(MAX_TILES_DOWN + 1);
    localparam int CI     = $clog2(MAX_TILES_ACROSS);
    localparam int RI     = $clog2(MAX_TILES_DOWN);
    localparam int TW     = drbm_pkg::TNUM_W;
    localparam int SPAN_W = drbm_pkg::PIX_W + 2;
    localparam int KSH    = TW + $clog2(TILE_SIZE);
    localparam int RCP_W  = TW + 2;
    localparam int PRD_W  = TW + RCP_W;
    // rounded-up reciprocal: exact quotient for every dividend below 2**TW
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << KSH) + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE));

    logic [drbm_pkg::CFG_W-1:0] r_cfg_across;
    logic [drbm_pkg::CFG_W-1:0] r_cfg_down;
    drbm_pkg::t_in              r_in;
    drbm_pkg::t_out             r_out;
    logic [TW-1:0]              r_dvd  [4];
    logic [TW-1:0]              r_tile [4];
    logic                       r_skip;
    logic                       r_clear;
    logic [MAX_TILES_ACROSS-1:0] r_mask;
    logic [RI-1:0]              r_row;
    logic [RI-1:0]              r_row_last;
    logic [MAX_TILES_ACROSS-1:0] r_mem [MAX_TILES_DOWN];
    logic [MAX_TILES_DOWN-1:0]  r_row_valid;
    logic [MAX_TILES_ACROSS-1:0] r_rd_word;
    logic                       r_rd_valid;
    logic                       r_flag_ok;
    logic [CI-1:0]              r_col;

    logic [AW-1:0]              w_across;
    logic [DNW-1:0]             w_down;
    logic [SPAN_W-1:0]          w_fx, w_lx, w_fy, w_ly;
    logic [PRD_W-1:0]           w_prod;
    logic                       w_c_out, w_r_out;
    logic [CI-1:0]              w_c0, w_c1;
    logic [RI-1:0]              w_r0, w_r1;
    logic [MAX_TILES_ACROSS-1:0] w_mark_mask;
    logic [MAX_TILES_ACROSS-1:0] w_use_mask;
    logic [MAX_TILES_ACROSS-1:0] w_old;
    logic [MAX_TILES_ACROSS-1:0] w_new;
    logic [RI-1:0]              w_rd_addr;
    logic                       w_div_done;
    logic [TW-1:0]              w_quot;
    logic [AW-1:0]              w_rem;

    // saturate the counts to 1..max
    assign w_across = (r_cfg_across == '0) ? AW'(1) :
                      (32'(r_cfg_across) > MAX_TILES_ACROSS) ? AW'(MAX_TILES_ACROSS) :
                      AW'(r_cfg_across);
    assign w_down   = (r_cfg_down == '0) ? DNW'(1) :
                      (32'(r_cfg_down) > MAX_TILES_DOWN) ? DNW'(MAX_TILES_DOWN) :
                      DNW'(r_cfg_down);

    // first and last pixel relative to the origin, two's complement
    assign w_fx = SPAN_W'(r_in.rect_left) - SPAN_W'(r_in.area_left);
    assign w_lx = SPAN_W'(r_in.rect_left) + SPAN_W'(r_in.rect_width) - SPAN_W'(1)
                - SPAN_W'(r_in.area_left);
    assign w_fy = SPAN_W'(r_in.rect_top) - SPAN_W'(r_in.area_top);
    assign w_ly = SPAN_W'(r_in.rect_top) + SPAN_W'(r_in.rect_height) - SPAN_W'(1)
                - SPAN_W'(r_in.area_top);

    assign w_prod = PRD_W'(r_dvd[i_cmd.mul_sel]) * PRD_W'(RECIP);

    assign w_c_out = (r_tile[0] >= TW'(w_across));
    assign w_r_out = (r_tile[2] >= TW'(w_down));
    assign w_c0    = r_tile[0][CI-1:0];
    assign w_c1    = (r_tile[1] >= TW'(w_across)) ? CI'(w_across - AW'(1))
                                                  : r_tile[1][CI-1:0];
    assign w_r0    = r_tile[2][RI-1:0];
    assign w_r1    = (r_tile[3] >= TW'(w_down)) ? RI'(w_down - DNW'(1))
                                                : r_tile[3][RI-1:0];

    always_comb begin
        for (int c = 0; c < MAX_TILES_ACROSS; c++) begin
            w_mark_mask[c] = (CI'(c) >= w_c0) && (CI'(c) <= w_c1);
            w_use_mask[c]  = (AW'(c) < w_across);
        end
    end

    // a row never written reads as cleared
    assign w_old     = r_rd_valid ? r_rd_word : '0;
    assign w_new     = r_clear ? (w_old & ~r_mask) : (w_old | r_mask);
    assign w_rd_addr = i_cmd.flag_rd ? w_quot[RI-1:0] : r_row;

    drbm_divider #(
        .DVD_W (TW),
        .DVS_W (AW)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_in.tile_number),
        .i_divisor   (w_across),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_across <= drbm_pkg::CFG_RESET_COUNT;
            r_cfg_down   <= drbm_pkg::CFG_RESET_COUNT;
            r_row_valid  <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == drbm_pkg::CFG_TILES_ACROSS)) begin
                r_cfg_across <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == drbm_pkg::CFG_TILES_DOWN)) begin
                r_cfg_down <= i_cfg_data;
            end
            if (i_cmd.row_wr) begin
                r_row_valid[r_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.span) begin
            r_dvd[0] <= w_fx[SPAN_W-1] ? '0 : w_fx[TW-1:0];
            r_dvd[1] <= w_lx[TW-1:0];
            r_dvd[2] <= w_fy[SPAN_W-1] ? '0 : w_fy[TW-1:0];
            r_dvd[3] <= w_ly[TW-1:0];
            r_skip   <= (r_in.rect_width == '0) || (r_in.rect_height == '0)
                      || w_lx[SPAN_W-1] || w_ly[SPAN_W-1];
        end
        if (i_cmd.mul) begin
            r_tile[i_cmd.mul_sel] <= TW'(w_prod >> KSH);
        end
        if (i_cmd.clip) begin
            r_skip     <= r_skip || w_c_out || w_r_out;
            r_mask     <= w_mark_mask;
            r_row      <= w_r0;
            r_row_last <= w_r1;
            r_clear    <= 1'b0;
        end
        if (i_cmd.clr_setup) begin
            r_skip     <= 1'b0;
            r_mask     <= w_use_mask;
            r_row      <= '0;
            r_row_last <= RI'(w_down - DNW'(1));
            r_clear    <= 1'b1;
        end
        if (i_cmd.row_rd || i_cmd.flag_rd) begin
            r_rd_word  <= r_mem[w_rd_addr];
            r_rd_valid <= r_row_valid[w_rd_addr];
        end
        if (i_cmd.flag_rd) begin
            r_flag_ok <= (w_quot < TW'(w_down));
            r_col     <= w_rem[CI-1:0];
        end
        if (i_cmd.row_wr) begin
            r_mem[r_row] <= w_new;
            r_row        <= r_row + RI'(1);
        end
        if (i_cmd.load_out) begin
            r_out.tile_dirty <= (r_in.mode == drbm_pkg::MODE_READ) && r_flag_ok
                              && r_rd_valid && r_rd_word[r_col];
            r_out.done_mode  <= r_in.mode;
        end
    end

    assign o_status.skip     = r_skip;
    assign o_status.last_row = (r_row == r_row_last);
    assign o_status.div_done = w_div_done;
    assign o_out_data        = r_out;

endmodule
`default_nettype wire

@@ rtl/damage_rect_block_marker_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// damage_rect_block_marker_unit: dirty tile bitmap over a capture area
// Clears, marks damaged rectangles into, and reads single flags from a map
// of TILE_SIZE square tiles; one result per transaction.
// ----------------------------------------------------------------------------
// Items are handled one at a time; the input is ready again once the result
// is in the output register, so the next item is taken while it waits.
// A mark passes through span, scaling, clipping and a row read and write per
// tile row touched, or skips to its result when none is touched; a clear reads
// and writes every row; a read waits on the bit-serial divider; an unused mode
// goes to its result at once. An item whose result finds the output register
// still occupied holds in its last state until the receiver takes the earlier
// result. Marks and clears are bound by the single row memory port, one row
// read and one row write per tile row. Each memory row carries a valid bit
// cleared at reset, so no clearing pass is needed; configuration writes are
// taken on any cycle and must land while the block is idle.
// ----------------------------------------------------------------------------
module damage_rect_block_marker_unit #(
    parameter int TILE_SIZE        = 16,
    parameter int MAX_TILES_ACROSS = 128,
    parameter int MAX_TILES_DOWN   = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire drbm_pkg::t_in                  i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output drbm_pkg::t_out                      o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [drbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [drbm_pkg::CFG_W-1:0]     i_cfg_data
);

    drbm_pkg::t_cmd    w_cmd;
    drbm_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    drbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_data.mode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    drbm_datapath #(
        .TILE_SIZE        (TILE_SIZE),
        .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
        .MAX_TILES_DOWN   (MAX_TILES_DOWN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

@@ dv/damage_rect_block_marker_unit_test.sv @@
// ----------------------------------------------------------------------------
// damage_rect_block_marker_unit_test: testbench of the dirty tile bitmap
// Sends clear, mark, read and spare-mode transactions over a series of grid
// sizes, from one column by one row up to the full map and past it. A local
// copy of the map predicts each tile flag and mode echo. Every result is
// checked in order while the sender pauses and the receiver stalls at random.
// ----------------------------------------------------------------------------
module damage_rect_block_marker_unit_test;
    import drbm_pkg::*;

    localparam int TILE_PX        = 16;
    localparam int MAX_ACROSS     = 128;
    localparam int MAX_DOWN       = 128;
    localparam int PIX_MAX        = (1 << PIX_W) - 1;
    localparam int NUM_PHASES     = 9;
    localparam int FIXED_PHASES   = 7;
    localparam int CMDS_PER_PHASE = 160;

    localparam logic [1:0]           MODE_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd2;

    localparam logic [CFG_W-1:0] ACROSS_SEQ [FIXED_PHASES] = '{8'd128, 8'd1, 8'd0, 8'd255,
                                                              8'd200, 8'd5, 8'd17};
    localparam logic [CFG_W-1:0] DOWN_SEQ   [FIXED_PHASES] = '{8'd128, 8'd1, 8'd0, 8'd255,
                                                              8'd3, 8'd128, 8'd9};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // local copy of the block's state
    bit [MAX_ACROSS-1:0] dirty_map [MAX_DOWN];
    logic [CFG_W-1:0]    cfg_tiles_across = CFG_RESET_COUNT;
    logic [CFG_W-1:0]    cfg_tiles_down   = CFG_RESET_COUNT;

    t_in  tile_cmds_pending [$];
    t_out flag_results_due [$];
    int   cmds_queued     = 0;
    int   results_checked = 0;
    int   mismatch_count  = 0;

    int   burst_left = 1;
    int   gap_left   = 0;
    int   open_left  = 0;
    int   stall_left = 0;

    damage_rect_block_marker_unit #(
        .TILE_SIZE       (TILE_PX),
        .MAX_TILES_ACROSS(MAX_ACROSS),
        .MAX_TILES_DOWN  (MAX_DOWN)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int eff_count(logic [CFG_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    // pixel span relative to the origin onto tile indices; zero when nothing is touched
    function automatic bit tile_span(int first, int last, int count,
                                     output int lo, output int hi);
        if (last < 0) return 1'b0;
        if (first < 0) first = 0;
        lo = first / TILE_PX;
        hi = last / TILE_PX;
        if (lo >= count) return 1'b0;
        if (hi >= count) hi = count - 1;
        return 1'b1;
    endfunction

    function automatic t_out apply_tile_cmd(t_in c);
        t_out res;
        int   across, down, row, col, c0, c1, r0, r1;
        int   rl, rt, rw, rh, al, at;
        across = eff_count(cfg_tiles_across, MAX_ACROSS);
        down   = eff_count(cfg_tiles_down, MAX_DOWN);
        rl = int'(c.rect_left);
        rt = int'(c.rect_top);
        rw = int'(c.rect_width);
        rh = int'(c.rect_height);
        al = int'(c.area_left);
        at = int'(c.area_top);
        res.tile_dirty = 1'b0;
        res.done_mode  = c.mode;
        case (c.mode)
            MODE_CLEAR: begin
                for (row = 0; row < down; row++)
                    for (col = 0; col < across; col++)
                        dirty_map[row][col] = 1'b0;
            end
            MODE_MARK: begin
                if (rw != 0 && rh != 0 &&
                    tile_span(rl - al, rl + rw - 1 - al, across, c0, c1) &&
                    tile_span(rt - at, rt + rh - 1 - at, down, r0, r1)) begin
                    for (row = r0; row <= r1; row++)
                        for (col = c0; col <= c1; col++)
                            dirty_map[row][col] = 1'b1;
                end
            end
            MODE_READ: begin
                row = int'(c.tile_number) / across;
                col = int'(c.tile_number) % across;
                if (row < down) res.tile_dirty = dirty_map[row][col];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in mk_cmd(logic [1:0] mode, int rl, int rt, int rw, int rh,
                                   int al, int at, int tn);
        t_in c;
        c.mode        = mode;
        c.rect_left   = PIX_W'(rl);
        c.rect_top    = PIX_W'(rt);
        c.rect_width  = PIX_W'(rw);
        c.rect_height = PIX_W'(rh);
        c.area_left   = PIX_W'(al);
        c.area_top    = PIX_W'(at);
        c.tile_number = TNUM_W'(tn);
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_pix(int v);
        if (v < 0) return '0;
        if (v > PIX_MAX) return PIX_W'(PIX_MAX);
        return PIX_W'(v);
    endfunction

    function automatic logic [PIX_W-1:0] random_extent(int typical);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return PIX_W'(PIX_MAX);
        if (pick == 2) return PIX_W'($urandom);
        return PIX_W'($urandom_range(1, typical));
    endfunction

    // random commands, rectangles mostly near the grid in use, with noise in the unused fields
    function automatic t_in random_tile_cmd(int across, int down);
        t_in         c;
        int          pick, off;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        c = noise[$bits(t_in)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            c.mode = MODE_CLEAR;
        end else if (pick < 52) begin
            c.mode = MODE_MARK;
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 3) != 0) c.area_left = PIX_W'($urandom_range(0, 300));
                if ($urandom_range(0, 3) != 0) c.area_top = PIX_W'($urandom_range(0, 300));
                off = $urandom_range(0, across * TILE_PX + 64);
                c.rect_left = clamp_pix(int'(c.area_left) + off - 32);
                off = $urandom_range(0, down * TILE_PX + 64);
                c.rect_top = clamp_pix(int'(c.area_top) + off - 32);
                c.rect_width  = random_extent(80);
                c.rect_height = random_extent(40);
            end
        end else if (pick < 96) begin
            c.mode = MODE_READ;
            if ($urandom_range(0, 4) != 0)
                c.tile_number = TNUM_W'($urandom_range(0, across * down + across - 1));
        end else begin
            c.mode = MODE_SPARE;
        end
        return c;
    endfunction

    task automatic queue_cmd(t_in c);
        tile_cmds_pending.push_back(c);
        cmds_queued++;
    endtask

    // only while idle: every queued command has produced its result
    task automatic write_grid_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TILES_ACROSS) cfg_tiles_across = val;
        else if (idx == CFG_TILES_DOWN) cfg_tiles_down = val;
    endtask

    task automatic drain_results();
        wait (results_checked == cmds_queued);
        repeat (8) @(posedge i_clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                flag_results_due.push_back(apply_tile_cmd(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0 || tile_cmds_pending.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= tile_cmds_pending.pop_front();
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: open windows and stalls of random length, some windows without a stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (flag_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0b/%0d",
                             $time, o_out_data.tile_dirty, o_out_data.done_mode);
                    mismatch_count++;
                end else begin
                    t_out want;
                    want = flag_results_due.pop_front();
                    if (o_out_data.tile_dirty !== want.tile_dirty) begin
                        $display("%0t: tile_dirty mismatch, expected %0b, actual %0b",
                                 $time, want.tile_dirty, o_out_data.tile_dirty);
                        mismatch_count++;
                    end
                    if (o_out_data.done_mode !== want.done_mode) begin
                        $display("%0t: done_mode mismatch, expected %0d, actual %0d",
                                 $time, want.done_mode, o_out_data.done_mode);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (open_left == 0) begin
                    open_left  = $urandom_range(1, 24);
                    stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    open_left--;
                end
            end
        end
    end

    initial begin
        int               p, n;
        logic [CFG_W-1:0] across_val, down_val;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at the reset grid of 128 by 128 tiles
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 16383));
        queue_cmd(mk_cmd(MODE_MARK, 0, 0, PIX_MAX, PIX_MAX, 0, 0, 0));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 16383));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(MODE_SPARE, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
                         16383));
        queue_cmd(mk_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 16383));
        // empty rectangles
        queue_cmd(mk_cmd(MODE_MARK, 0, 0, 0, 5, 0, 0, 0));
        queue_cmd(mk_cmd(MODE_MARK, 0, 0, 5, 0, 0, 0, 0));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
        // wholly left of and wholly above the origin
        queue_cmd(mk_cmd(MODE_MARK, 10, 500, 5, 5, 100, 0, 0));
        queue_cmd(mk_cmd(MODE_MARK, 500, 10, 5, 5, 0, 100, 0));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 31 * 128 + 25));
        // straddling the origin: tiles 0..1 both ways
        queue_cmd(mk_cmd(MODE_MARK, 90, 90, 30, 30, 100, 100, 0));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 1));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 129));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 2));
        // wholly past and straddling the far edge of the grid
        queue_cmd(mk_cmd(MODE_MARK, 4000, 0, 100, 10, 0, 0, 0));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 127));
        queue_cmd(mk_cmd(MODE_MARK, 2040, 2040, 500, 500, 0, 0, 0));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 16383));
        queue_cmd(mk_cmd(MODE_MARK, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
                         16383));
        queue_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 8191));
        drain_results();

        // grid sizes change between phases; flags outside a shrunk grid survive
        for (p = 0; p < NUM_PHASES; p++) begin
            across_val = (p < FIXED_PHASES) ? ACROSS_SEQ[p] : CFG_W'($urandom_range(0, 255));
            down_val   = (p < FIXED_PHASES) ? DOWN_SEQ[p] : CFG_W'($urandom_range(0, 255));
            write_grid_reg(CFG_TILES_ACROSS, across_val);
            write_grid_reg(CFG_TILES_DOWN, down_val);
            if (p == FIXED_PHASES - 1) write_grid_reg(CFG_SPARE_IDX, '1);
            for (n = 0; n < CMDS_PER_PHASE; n++)
                queue_cmd(random_tile_cmd(eff_count(cfg_tiles_across, MAX_ACROSS),
                                          eff_count(cfg_tiles_down, MAX_DOWN)));
            drain_results();
        end

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && flag_results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
